// File: rtl/pgrc_pkg.sv
package pgrc_pkg;

   // Default sizing
   localparam int NUM_PAGES_DEF       = 32768;
   localparam int FIRST_FREE_PAGE_DEF = 64;
   localparam int COUNT_BITS_DEF      = 8;

   // Page index width on the stream ports
   localparam int PAGE_W = 15;

   typedef enum logic [1:0] {
      FN_ALLOC  = 2'd0,
      FN_FREE   = 2'd1,
      FN_ADDREF = 2'd2,
      FN_DEREF  = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      STAT_OK      = 2'd0,
      STAT_NOMEM   = 2'd1,
      STAT_BADPAGE = 2'd2,
      STAT_ZERO    = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EXEC,
      ST_EXEC2
   } state_type;

endpackage

// File: rtl/pgrc_ram.sv
module pgrc_ram #(
   parameter int WIDTH = pgrc_pkg::COUNT_BITS_DEF,
   parameter int DEPTH = pgrc_pkg::NUM_PAGES_DEF
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/page_refcount_allocator_top.sv
// Page frame allocator with per-page reference counts.
//
// Request channel (req_*): one transaction per operation. req_tuser holds the
// operation (allocate, free, add reference, copy-on-write dereference) and
// req_tdata the page index, ignored by allocate.
// Response channel (rsp_*): exactly one transaction per request, in order,
// carrying status, page_out, needs_copy and released.
//
// Sequence: a request is accepted with its memory read, then modified and written
// back; a dereference that pops a new page adds a second write to the
// single-write-port count memory. The response is registered and appears the
// cycle after the modify step.
//
// Free pages live in a LIFO stack memory, counts in a second memory. Stack
// entries below the lowest stack top seen since reset still hold their reset
// contents and are produced from the index instead of the memory.
//
// Reset: the count memory is cleared one entry per cycle, with req_tready
// low. When the response is stalled, one more request is taken and
// processed up to the modify step, where it waits for the output register
// to drain.
module page_refcount_allocator_top #(
   parameter int NUM_PAGES       = pgrc_pkg::NUM_PAGES_DEF,
   parameter int FIRST_FREE_PAGE = pgrc_pkg::FIRST_FREE_PAGE_DEF,
   parameter int COUNT_BITS      = pgrc_pkg::COUNT_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [14:0] page, [15] zero
   input  logic [1:0]  req_tuser,   // [1:0] func

   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [14:0] page_out, [15] zero
   output logic [3:0]  rsp_tuser    // [1:0] status, [2] needs_copy, [3] released
);

   localparam int IDX_W      = $clog2(NUM_PAGES);
   localparam int TOP_W      = $clog2(NUM_PAGES + 1);
   localparam int INIT_COUNT = (NUM_PAGES > FIRST_FREE_PAGE) ?
                               (NUM_PAGES - FIRST_FREE_PAGE) : 0;
   localparam int PW         = pgrc_pkg::PAGE_W;

   pgrc_pkg::state_type  state_ff, state_in;
   logic [IDX_W-1:0]     clr_ff, clr_in;
   logic [TOP_W-1:0]     top_ff, top_in;
   logic [TOP_W-1:0]     low_ff, low_in;     // lowest stack top since reset
   pgrc_pkg::func_type   func_ff, func_in;
   logic [PW-1:0]        page_ff, page_in;
   logic [IDX_W-1:0]     idx_ff, idx_in;
   logic                 valid_pg_ff, valid_pg_in;
   logic [IDX_W-1:0]     np_ff, np_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   pgrc_pkg::status_type rsp_status_ff, rsp_status_in;
   logic [PW-1:0]        rsp_page_ff, rsp_page_in;
   logic                 rsp_copy_ff, rsp_copy_in;
   logic                 rsp_rel_ff, rsp_rel_in;

   logic                  cnt_we, cnt_re;
   logic [IDX_W-1:0]      cnt_waddr, cnt_raddr;
   logic [COUNT_BITS-1:0] cnt_wdata, cnt_rdata;
   logic                  stk_we, stk_re;
   logic [IDX_W-1:0]      stk_waddr, stk_raddr, stk_wdata, stk_rdata;

   logic [31:0]           req_page_ext, orig_ext, np_ext;
   logic [TOP_W-1:0]      top_m1;
   logic [IDX_W-1:0]      np;
   logic [COUNT_BITS-1:0] cnt;
   logic                  rsp_free;
   logic                  req_ok;

   pgrc_ram #(.WIDTH(COUNT_BITS), .DEPTH(NUM_PAGES)) u_cnt_ram (
      .clock   (clock),
      .wr_en   (cnt_we),
      .wr_addr (cnt_waddr),
      .wr_data (cnt_wdata),
      .rd_en   (cnt_re),
      .rd_addr (cnt_raddr),
      .rd_data (cnt_rdata)
   );

   pgrc_ram #(.WIDTH(IDX_W), .DEPTH(NUM_PAGES)) u_stk_ram (
      .clock   (clock),
      .wr_en   (stk_we),
      .wr_addr (stk_waddr),
      .wr_data (stk_wdata),
      .rd_en   (stk_re),
      .rd_addr (stk_raddr),
      .rd_data (stk_rdata)
   );

   assign req_page_ext = 32'(req_tdata[PW-1:0]);
   assign req_ok       = (req_page_ext >= 32'(FIRST_FREE_PAGE)) &&
                         (req_page_ext < 32'(NUM_PAGES));
   assign top_m1       = top_ff - 1'b1;
   // Never-overwritten stack entries still hold their reset page
   assign orig_ext     = 32'(FIRST_FREE_PAGE) + 32'(top_m1);
   assign np           = (top_m1 < low_ff) ? orig_ext[IDX_W-1:0] : stk_rdata;
   assign np_ext       = 32'(np);
   assign cnt          = cnt_rdata;
   assign rsp_free     = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pgrc_pkg::ST_CLEAR;
         clr_ff       <= '0;
         top_ff       <= TOP_W'(INIT_COUNT);
         low_ff       <= TOP_W'(INIT_COUNT);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         top_ff       <= top_in;
         low_ff       <= low_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff       <= func_in;
      page_ff       <= page_in;
      idx_ff        <= idx_in;
      valid_pg_ff   <= valid_pg_in;
      np_ff         <= np_in;
      rsp_status_ff <= rsp_status_in;
      rsp_page_ff   <= rsp_page_in;
      rsp_copy_ff   <= rsp_copy_in;
      rsp_rel_ff    <= rsp_rel_in;
   end

   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      top_in        = top_ff;
      low_in        = low_ff;
      func_in       = func_ff;
      page_in       = page_ff;
      idx_in        = idx_ff;
      valid_pg_in   = valid_pg_ff;
      np_in         = np_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_page_in   = rsp_page_ff;
      rsp_copy_in   = rsp_copy_ff;
      rsp_rel_in    = rsp_rel_ff;
      req_tready    = 1'b0;
      cnt_we        = 1'b0;
      cnt_waddr     = idx_ff;
      cnt_wdata     = '0;
      cnt_re        = 1'b0;
      cnt_raddr     = req_page_ext[IDX_W-1:0];
      stk_we        = 1'b0;
      stk_waddr     = top_ff[IDX_W-1:0];
      stk_wdata     = idx_ff;
      stk_re        = 1'b0;
      stk_raddr     = top_m1[IDX_W-1:0];

      unique case (state_ff)
         pgrc_pkg::ST_CLEAR: begin
            cnt_we    = 1'b1;
            cnt_waddr = clr_ff;
            if (clr_ff == IDX_W'(NUM_PAGES - 1)) begin
               state_in = pgrc_pkg::ST_IDLE;
            end else begin
               clr_in = clr_ff + 1'b1;
            end
         end

         pgrc_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               func_in     = pgrc_pkg::func_type'(req_tuser);
               page_in     = req_tdata[PW-1:0];
               idx_in      = req_page_ext[IDX_W-1:0];
               valid_pg_in = req_ok;
               cnt_re      = 1'b1;
               stk_re      = 1'b1;
               state_in    = pgrc_pkg::ST_EXEC;
            end
         end

         pgrc_pkg::ST_EXEC: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = pgrc_pkg::STAT_OK;
               rsp_page_in   = '0;
               rsp_copy_in   = 1'b0;
               rsp_rel_in    = 1'b0;
               state_in      = pgrc_pkg::ST_IDLE;
               if (func_ff == pgrc_pkg::FN_ALLOC) begin
                  if (top_ff == '0) begin
                     rsp_status_in = pgrc_pkg::STAT_NOMEM;
                  end else begin
                     cnt_we      = 1'b1;
                     cnt_waddr   = np;
                     cnt_wdata   = COUNT_BITS'(1);
                     top_in      = top_m1;
                     rsp_page_in = np_ext[PW-1:0];
                     if (top_m1 < low_ff) begin
                        low_in = top_m1;
                     end
                  end
               end else if (!valid_pg_ff) begin
                  rsp_status_in = pgrc_pkg::STAT_BADPAGE;
               end else begin
                  case (func_ff)
                     pgrc_pkg::FN_FREE: begin
                        if (cnt == '0) begin
                           rsp_status_in = pgrc_pkg::STAT_ZERO;
                        end else begin
                           cnt_we      = 1'b1;
                           cnt_wdata   = cnt - 1'b1;
                           rsp_page_in = page_ff;
                           if (cnt == COUNT_BITS'(1)) begin
                              rsp_rel_in = 1'b1;
                              // push is dropped when the stack is full
                              if (top_ff < TOP_W'(NUM_PAGES)) begin
                                 stk_we = 1'b1;
                                 top_in = top_ff + 1'b1;
                              end
                           end
                        end
                     end
                     pgrc_pkg::FN_ADDREF: begin
                        cnt_we      = 1'b1;
                        cnt_wdata   = (&cnt) ? cnt : cnt + 1'b1;
                        rsp_page_in = page_ff;
                     end
                     default: begin
                        // copy-on-write dereference
                        if (cnt <= COUNT_BITS'(1)) begin
                           rsp_page_in = page_ff;
                        end else if (top_ff == '0) begin
                           rsp_status_in = pgrc_pkg::STAT_NOMEM;
                        end else begin
                           cnt_we      = 1'b1;
                           cnt_wdata   = cnt - 1'b1;
                           top_in      = top_m1;
                           np_in       = np;
                           rsp_page_in = np_ext[PW-1:0];
                           rsp_copy_in = 1'b1;
                           state_in    = pgrc_pkg::ST_EXEC2;
                           if (top_m1 < low_ff) begin
                              low_in = top_m1;
                           end
                        end
                     end
                  endcase
               end
            end
         end

         pgrc_pkg::ST_EXEC2: begin
            // New page gets count 1; if it is the old page itself, it is
            // written as zero, as if the decrement came after the set.
            cnt_we    = 1'b1;
            cnt_waddr = np_ff;
            cnt_wdata = (np_ff == idx_ff) ? '0 : COUNT_BITS'(1);
            state_in  = pgrc_pkg::ST_IDLE;
         end

         default: begin
            state_in = pgrc_pkg::ST_IDLE;
         end
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_page_ff};
   assign rsp_tuser  = {rsp_rel_ff, rsp_copy_ff, rsp_status_ff};

`ifndef NO_ASSERTIONS
   a_top_range: assert property (@(posedge clock) disable iff (reset)
      top_ff <= TOP_W'(NUM_PAGES))
      else $error("free stack top beyond capacity");

   a_low_mark: assert property (@(posedge clock) disable iff (reset)
      low_ff <= top_ff && low_ff <= TOP_W'(INIT_COUNT))
      else $error("stack low mark above stack top");

   a_no_accept_clear: assert property (@(posedge clock) disable iff (reset)
      state_ff == pgrc_pkg::ST_CLEAR |-> !req_tready)
      else $error("request taken during count clear");

   a_copy_second_write: assert property (@(posedge clock) disable iff (reset)
      state_ff == pgrc_pkg::ST_EXEC && rsp_free && rsp_copy_in
      |=> state_ff == pgrc_pkg::ST_EXEC2 && rsp_valid_ff)
      else $error("copy result without second count write");

   a_resp_one_per_req: assert property (@(posedge clock) disable iff (reset)
      state_ff == pgrc_pkg::ST_EXEC && !rsp_free |=> state_ff == pgrc_pkg::ST_EXEC)
      else $error("result dropped while output register busy");
`endif

endmodule
